### rtl/buffer_pool_clock_replacement_top_assert.svh
// Assertion macros used by the buffer pool frame table datapath.
`ifndef BUFFER_POOL_CLOCK_REPLACEMENT_TOP_ASSERT_SVH
`define BUFFER_POOL_CLOCK_REPLACEMENT_TOP_ASSERT_SVH

// Condition must hold at every edge outside reset.
`define BPC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define BPC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/bpc_pkg.sv
// Shared types, codes and constants of the buffer pool frame table.
package bpc_pkg;

  localparam int DEF_FRAMES     = 64;
  localparam int DEF_BLOCK_BITS = 24;
  localparam int DEF_PIN_BITS   = 8;

  localparam int KIND_W     = 2;
  localparam int BLK_PORT_W = 24;
  localparam int FRM_PORT_W = 6;
  localparam int STATUS_W   = 3;

  typedef enum logic [KIND_W-1:0] {
    K_FETCH = 2'd0,
    K_UNPIN = 2'd1,
    K_MARK  = 2'd2,
    K_FLUSH = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT             = 3'd0,
    ST_MISS_LOAD       = 3'd1,
    ST_MISS_ZERO       = 3'd2,
    ST_ALL_PINNED      = 3'd3,
    ST_UNPIN_UNDERFLOW = 3'd4,
    ST_DONE            = 3'd5
  } status_t;

  // Datapath micro-operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOOKUP,
    OP_HIT_SEL,
    OP_HIT_DONE,
    OP_FULL,
    OP_SWEEP,
    OP_VICTIM_RD,
    OP_VICTIM_WR,
    OP_UNPIN_RD,
    OP_UNPIN_WR,
    OP_MARK,
    OP_FLUSH_INIT,
    OP_FLUSH_RD,
    OP_FLUSH_WR,
    OP_FLUSH_NONE
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_RESOLVE,
    S_HIT,
    S_FULL,
    S_SWEEP,
    S_VICTIM,
    S_UNPIN,
    S_MARK,
    S_FLUSH_FIRST,
    S_FLUSH_RD,
    S_FLUSH_WR,
    S_FLUSH_NONE
  } bpc_state_t;

  typedef struct packed {
    logic   load;
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  hit;
    logic  any_free;
    logic  hand_pinned;
    logic  hand_ref;
    logic  out_free;
    logic  pend_empty;
    logic  pend_last;
  } stat_t;

endpackage

### rtl/bpc_if.sv
// Request and result channel interfaces of the buffer pool frame table.
interface bpc_req_if import bpc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [BLK_PORT_W-1:0] block_number;
  logic                  read_wanted;
  logic [FRM_PORT_W-1:0] frame_index;

  modport source (output valid, kind, block_number, read_wanted, frame_index,
                  input ready);
  modport sink   (input valid, kind, block_number, read_wanted, frame_index,
                  output ready);
endinterface

interface bpc_rsp_if import bpc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FRM_PORT_W-1:0] frame_out;
  logic [STATUS_W-1:0]   status;
  logic                  write_back;
  logic [BLK_PORT_W-1:0] write_back_block;
  logic                  last;

  modport source (output valid, frame_out, status, write_back, write_back_block, last,
                  input ready);
  modport sink   (input valid, frame_out, status, write_back, write_back_block, last,
                  output ready);
endinterface

### rtl/bpc_datapath.sv
// Frame table datapath: tag compare, frame flags, clock hand, memories, result register.
`include "buffer_pool_clock_replacement_top_assert.svh"

module bpc_datapath import bpc_pkg::*; #(
  parameter int FRAMES     = DEF_FRAMES,
  parameter int BLOCK_BITS = DEF_BLOCK_BITS,
  parameter int PIN_BITS   = DEF_PIN_BITS
) (
  input  logic       clk,
  input  logic       rst,
  bpc_req_if.sink    req,
  bpc_rsp_if.source  rsp,
  input  cmd_t       cmd,
  output stat_t      st
);

  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam logic [FW-1:0]       HAND_LAST = FW'(FRAMES - 1);
  localparam logic [31:0]         FRAMES_U  = 32'(FRAMES);
  localparam logic [PIN_BITS-1:0] PIN_MAX   = '1;
  localparam logic [PIN_BITS-1:0] PIN_ONE   = PIN_BITS'(1);
  localparam logic [FRAMES-1:0]   SEL_ONE   = FRAMES'(1);

  // captured transaction
  kind_t                 req_kind;
  logic [BLOCK_BITS-1:0] req_blk;
  logic                  req_load;
  logic [FRM_PORT_W-1:0] req_idx;

  // per-frame flags and tag registers
  logic [FRAMES-1:0]     vld;
  logic [FRAMES-1:0]     pinned;
  logic [FRAMES-1:0]     dirty;
  logic [FRAMES-1:0]     refm;
  logic [BLOCK_BITS-1:0] cam_blk [FRAMES];
  logic [FW-1:0]         hand;
  logic [FW-1:0]         hand_next;

  logic [FRAMES-1:0]     match;
  logic [FRAMES-1:0]     match_q;
  logic                  free_q;
  logic [FRAMES-1:0]     pend;
  logic [FW-1:0]         hit_idx;
  logic [FW-1:0]         pend_idx;
  logic [FW-1:0]         sel;
  logic [FRAMES-1:0]     sel_mask;

  // pin counts live in memory; the pinned bit says whether an entry holds a count
  logic [PIN_BITS-1:0]   pin_mem [FRAMES];
  logic [PIN_BITS-1:0]   pin_rd;
  logic                  pin_rdv;
  logic [PIN_BITS-1:0]   pin_eff;
  logic                  pin_re;
  logic [FW-1:0]         pin_raddr;
  logic                  pin_we;
  logic [PIN_BITS-1:0]   pin_wdata;

  // copy of the tags for addressed reads
  logic [BLOCK_BITS-1:0] blk_mem [FRAMES];
  logic [BLOCK_BITS-1:0] blk_rd;
  logic                  blk_re;
  logic [FW-1:0]         blk_raddr;

  logic [BLOCK_BITS+BLK_PORT_W-1:0] blk_in_wide;
  logic [BLOCK_BITS+BLK_PORT_W-1:0] blk_out_wide;
  logic [FW+FRM_PORT_W-1:0]         idx_wide;
  logic [FW+FRM_PORT_W-1:0]         sel_wide;
  logic [FW-1:0]                    idx_trunc;
  logic [FRM_PORT_W-1:0]            sel_port;
  logic [BLK_PORT_W-1:0]            blk_port;
  logic                             idx_ok;

  // result register
  logic                  out_valid;
  logic                  out_free;
  logic [FRM_PORT_W-1:0] o_frame;
  status_t               o_status;
  logic                  o_wb;
  logic [BLK_PORT_W-1:0] o_wbb;
  logic                  o_last;
  logic                  emit;
  logic [FRM_PORT_W-1:0] n_frame;
  status_t               n_status;
  logic                  n_wb;
  logic [BLK_PORT_W-1:0] n_wbb;
  logic                  n_last;

  assign blk_in_wide  = {{BLOCK_BITS{1'b0}}, req.block_number};
  assign blk_out_wide = {{BLK_PORT_W{1'b0}}, blk_rd};
  assign blk_port     = blk_out_wide[BLK_PORT_W-1:0];
  assign idx_wide     = {{FW{1'b0}}, req_idx};
  assign idx_trunc    = idx_wide[FW-1:0];
  assign sel_wide     = {{FRM_PORT_W{1'b0}}, sel};
  assign sel_port     = sel_wide[FRM_PORT_W-1:0];
  assign idx_ok       = {{(32-FRM_PORT_W){1'b0}}, req_idx} < FRAMES_U;
  assign hand_next    = (hand == HAND_LAST) ? '0 : hand + FW'(1);
  assign sel_mask     = SEL_ONE << sel;
  assign pin_eff      = pin_rdv ? pin_rd : '0;
  assign out_free     = !out_valid || rsp.ready;

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      match[i] = vld[i] && (cam_blk[i] == req_blk);
    end
  end

  // lowest set bit wins
  always_comb begin
    hit_idx  = '0;
    pend_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match_q[i]) hit_idx = FW'(i);
      if (pend[i]) pend_idx = FW'(i);
    end
  end

  always_comb begin
    pin_re    = (cmd.op == OP_HIT_SEL) || (cmd.op == OP_UNPIN_RD);
    pin_raddr = (cmd.op == OP_HIT_SEL) ? hit_idx : idx_trunc;
    blk_re    = (cmd.op == OP_VICTIM_RD) || (cmd.op == OP_FLUSH_RD);
    blk_raddr = (cmd.op == OP_VICTIM_RD) ? hand : pend_idx;
    pin_we    = 1'b0;
    pin_wdata = PIN_ONE;
    case (cmd.op)
      OP_HIT_DONE: begin
        pin_we    = 1'b1;
        pin_wdata = (pin_eff == PIN_MAX) ? pin_eff : pin_eff + PIN_ONE;
      end
      OP_VICTIM_WR: begin
        pin_we    = 1'b1;
        pin_wdata = PIN_ONE;
      end
      OP_UNPIN_WR: begin
        pin_we    = idx_ok && (pin_eff != '0);
        pin_wdata = pin_eff - PIN_ONE;
      end
      default: begin
        pin_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pin_re) begin
      pin_rd  <= pin_mem[pin_raddr];
      pin_rdv <= pinned[pin_raddr];
    end
    if (pin_we) pin_mem[sel] <= pin_wdata;
  end

  always_ff @(posedge clk) begin
    if (blk_re) blk_rd <= blk_mem[blk_raddr];
    if (cmd.op == OP_VICTIM_WR) blk_mem[sel] <= req_blk;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind <= kind_t'(req.kind);
      req_blk  <= blk_in_wide[BLOCK_BITS-1:0];
      req_load <= req.read_wanted;
      req_idx  <= req.frame_index;
    end
    if (cmd.op == OP_LOOKUP) begin
      match_q <= match;
      free_q  <= !(&pinned);
    end
    case (cmd.op)
      OP_HIT_SEL:   sel <= hit_idx;
      OP_VICTIM_RD: sel <= hand;
      OP_UNPIN_RD:  sel <= idx_trunc;
      OP_FLUSH_RD:  sel <= pend_idx;
      default:      sel <= sel;
    endcase
    if (cmd.op == OP_VICTIM_WR) cam_blk[sel] <= req_blk;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      pinned    <= '0;
      dirty     <= '0;
      refm      <= '0;
      hand      <= '0;
      pend      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_HIT_DONE: begin
          pinned[sel] <= 1'b1;
          refm[sel]   <= 1'b1;
        end
        OP_SWEEP: begin
          if (!pinned[hand]) refm[hand] <= 1'b0;
          hand <= hand_next;
        end
        OP_VICTIM_RD: begin
          hand <= hand_next;
        end
        OP_VICTIM_WR: begin
          vld[sel]    <= 1'b1;
          pinned[sel] <= 1'b1;
          dirty[sel]  <= 1'b0;
          refm[sel]   <= 1'b1;
        end
        OP_UNPIN_WR: begin
          if (idx_ok && (pin_eff != '0)) pinned[sel] <= (pin_eff != PIN_ONE);
        end
        OP_MARK: begin
          if (idx_ok && vld[idx_trunc]) dirty[idx_trunc] <= 1'b1;
        end
        OP_FLUSH_INIT: begin
          pend <= vld & dirty;
        end
        OP_FLUSH_WR: begin
          dirty[sel] <= 1'b0;
          pend[sel]  <= 1'b0;
        end
        default: begin
          hand <= hand;
        end
      endcase
    end
  end

  always_comb begin
    emit     = 1'b1;
    n_frame  = '0;
    n_status = ST_DONE;
    n_wb     = 1'b0;
    n_wbb    = '0;
    n_last   = 1'b1;
    case (cmd.op)
      OP_HIT_DONE: begin
        n_frame  = sel_port;
        n_status = ST_HIT;
      end
      OP_FULL: begin
        n_status = ST_ALL_PINNED;
      end
      OP_VICTIM_WR: begin
        n_frame  = sel_port;
        n_status = req_load ? ST_MISS_LOAD : ST_MISS_ZERO;
        n_wb     = vld[sel] && dirty[sel];
        n_wbb    = (vld[sel] && dirty[sel]) ? blk_port : '0;
      end
      OP_UNPIN_WR: begin
        n_frame  = req_idx;
        n_status = (idx_ok && (pin_eff == '0)) ? ST_UNPIN_UNDERFLOW : ST_DONE;
      end
      OP_MARK: begin
        n_frame = req_idx;
      end
      OP_FLUSH_WR: begin
        n_frame = sel_port;
        n_wb    = 1'b1;
        n_wbb   = blk_port;
        n_last  = (pend & ~sel_mask) == '0;
      end
      OP_FLUSH_NONE: begin
        n_frame = '0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_frame  <= n_frame;
      o_status <= n_status;
      o_wb     <= n_wb;
      o_wbb    <= n_wbb;
      o_last   <= n_last;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.frame_out        = o_frame;
  assign rsp.status           = o_status;
  assign rsp.write_back       = o_wb;
  assign rsp.write_back_block = o_wbb;
  assign rsp.last             = o_last;

  assign st.kind        = req_kind;
  assign st.hit         = |match_q;
  assign st.any_free    = free_q;
  assign st.hand_pinned = pinned[hand];
  assign st.hand_ref    = refm[hand];
  assign st.out_free    = out_free;
  assign st.pend_empty  = pend == '0;
  assign st.pend_last   = (pend & ~sel_mask) == '0;

  `BPC_ASSERT_IMPLY(a_emit_free, emit, out_free, "result written over an untaken one")
  `BPC_ASSERT_IMPLY(a_hit_match, cmd.op == OP_HIT_SEL, match_q != '0, "hit without a match")
  `BPC_ASSERT_IMPLY(a_victim_free, cmd.op == OP_VICTIM_WR, !pinned[sel] && !refm[sel], "victim is pinned or referenced")
  `BPC_ASSERT_IMPLY(a_flush_pend, cmd.op == OP_FLUSH_WR, pend[sel], "flush reports a frame not pending")
  `BPC_ASSERT_ALWAYS(a_hand_range, hand <= HAND_LAST, "clock hand beyond last frame")

endmodule

### rtl/bpc_ctrl.sv
// Frame table controller: sequences each request through datapath micro-operations.
module bpc_ctrl import bpc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  bpc_state_t state;
  bpc_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.kind)
          K_FETCH: begin
            cmd.op     = OP_LOOKUP;
            state_next = S_RESOLVE;
          end
          K_UNPIN: begin
            cmd.op     = OP_UNPIN_RD;
            state_next = S_UNPIN;
          end
          K_MARK: begin
            state_next = S_MARK;
          end
          K_FLUSH: begin
            cmd.op     = OP_FLUSH_INIT;
            state_next = S_FLUSH_FIRST;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_RESOLVE: begin
        if (st.hit) begin
          cmd.op     = OP_HIT_SEL;
          state_next = S_HIT;
        end else if (!st.any_free) begin
          state_next = S_FULL;
        end else begin
          state_next = S_SWEEP;
        end
      end
      S_HIT: begin
        if (st.out_free) begin
          cmd.op     = OP_HIT_DONE;
          state_next = S_IDLE;
        end
      end
      S_FULL: begin
        if (st.out_free) begin
          cmd.op     = OP_FULL;
          state_next = S_IDLE;
        end
      end
      S_SWEEP: begin
        // pinned frames are passed over, referenced ones get a second chance
        if (st.hand_pinned || st.hand_ref) begin
          cmd.op = OP_SWEEP;
        end else begin
          cmd.op     = OP_VICTIM_RD;
          state_next = S_VICTIM;
        end
      end
      S_VICTIM: begin
        if (st.out_free) begin
          cmd.op     = OP_VICTIM_WR;
          state_next = S_IDLE;
        end
      end
      S_UNPIN: begin
        if (st.out_free) begin
          cmd.op     = OP_UNPIN_WR;
          state_next = S_IDLE;
        end
      end
      S_MARK: begin
        if (st.out_free) begin
          cmd.op     = OP_MARK;
          state_next = S_IDLE;
        end
      end
      S_FLUSH_FIRST: begin
        if (st.pend_empty) begin
          state_next = S_FLUSH_NONE;
        end else begin
          cmd.op     = OP_FLUSH_RD;
          state_next = S_FLUSH_WR;
        end
      end
      S_FLUSH_RD: begin
        cmd.op     = OP_FLUSH_RD;
        state_next = S_FLUSH_WR;
      end
      S_FLUSH_WR: begin
        if (st.out_free) begin
          cmd.op     = OP_FLUSH_WR;
          state_next = st.pend_last ? S_IDLE : S_FLUSH_RD;
        end
      end
      S_FLUSH_NONE: begin
        if (st.out_free) begin
          cmd.op     = OP_FLUSH_NONE;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/buffer_pool_clock_replacement_top.sv
// Top level of the buffer pool frame table with clock replacement.
// Frame table of a page buffer pool. A fetch searches all valid frames for the block
// in parallel; a hit raises the pin count (saturating) and sets the reference bit, a
// miss walks the clock hand one frame per cycle, skipping pinned frames and clearing
// reference bits, and takes over the first unpinned, unreferenced frame, reporting its
// old block for write-back when dirty. If no frame is unpinned, status all-pinned is
// returned and nothing changes. Unpin, mark-dirty and flush-all complete the request
// set; a flush returns one result per valid dirty frame in ascending order (last marks
// the final one), or one empty result. One request is processed at a time. A miss
// steps the clock hand past at most 2*FRAMES frames, and a flush reads each dirty
// frame's block through the single read port of the tag memory before it writes
// that frame's result. A request whose result finds the output register still full
// waits until rsp.ready takes the old one. A finished result waits in an output
// register while the next request is accepted. No clearing pass runs after reset.
module buffer_pool_clock_replacement_top import bpc_pkg::*; #(
  parameter int FRAMES     = DEF_FRAMES,
  parameter int BLOCK_BITS = DEF_BLOCK_BITS,
  parameter int PIN_BITS   = DEF_PIN_BITS
) (
  input  logic      clk,
  input  logic      rst,
  bpc_req_if.sink   req,
  bpc_rsp_if.source rsp
);

  cmd_t  cmd;
  stat_t st;
  logic  in_ready;

  assign req.ready = in_ready;

  bpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  bpc_datapath #(
    .FRAMES     (FRAMES),
    .BLOCK_BITS (BLOCK_BITS),
    .PIN_BITS   (PIN_BITS)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .st  (st)
  );

endmodule

### bench/buffer_pool_clock_replacement_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the buffer pool frame table with clock replacement.
module buffer_pool_clock_replacement_top_tb;
  import bpc_pkg::*;

  localparam int NFR        = DEF_FRAMES;
  localparam int PIN_MAX    = (1 << DEF_PIN_BITS) - 1;
  localparam int HAND_STEPS = 3 * NFR;

  typedef struct {
    logic [FRM_PORT_W-1:0] frame;
    status_t               status;
    logic                  wb;
    logic [BLK_PORT_W-1:0] wb_block;
    logic                  last;
  } pool_result_t;

  logic clk = 1'b0;
  logic rst;

  bpc_req_if req ();
  bpc_rsp_if rsp ();

  buffer_pool_clock_replacement_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Shadow frame table
  logic [BLK_PORT_W-1:0]   tab_block [NFR];
  logic                    tab_valid [NFR];
  logic [DEF_PIN_BITS-1:0] tab_pins  [NFR];
  logic                    tab_dirty [NFR];
  logic                    tab_ref   [NFR];
  logic [FRM_PORT_W-1:0]   tab_hand;

  pool_result_t pending_results [$];
  pool_result_t oldest;
  int errors;
  int results_seen;
  bit tx_idling;
  bit rx_idling;
  int rx_hold_request;
  int rx_hold_left;
  int rx_gap_left;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void push_result(logic [FRM_PORT_W-1:0] f, status_t st, logic wb,
                                      logic [BLK_PORT_W-1:0] wbb, logic last);
    pool_result_t r;
    r.frame    = f;
    r.status   = st;
    r.wb       = wb;
    r.wb_block = wbb;
    r.last     = last;
    pending_results.push_back(r);
  endfunction

  // Apply one request to the shadow table and queue the results it should produce.
  function automatic void predict_request(kind_t k, logic [BLK_PORT_W-1:0] blk, logic rd,
                                          logic [FRM_PORT_W-1:0] f);
    int  hit_at;
    int  victim;
    int  c;
    int  last_dirty;
    bit  any_free;
    logic old_wb;
    logic [BLK_PORT_W-1:0] old_blk;
    hit_at     = -1;
    victim     = -1;
    last_dirty = -1;
    any_free   = 1'b0;
    case (k)
      K_FETCH: begin
        for (int i = 0; i < NFR; i++)
          if (hit_at < 0 && tab_valid[i] && tab_block[i] == blk) hit_at = i;
        if (hit_at >= 0) begin
          if (tab_pins[hit_at] != PIN_MAX) tab_pins[hit_at] = tab_pins[hit_at] + 1'b1;
          tab_ref[hit_at] = 1'b1;
          push_result(FRM_PORT_W'(hit_at), ST_HIT, 1'b0, '0, 1'b1);
        end else begin
          for (int i = 0; i < NFR; i++)
            if (tab_pins[i] == 0) any_free = 1'b1;
          if (!any_free) begin
            push_result('0, ST_ALL_PINNED, 1'b0, '0, 1'b1);
          end else begin
            // hand skips pinned frames and gives referenced ones a second chance
            for (int s = 0; s < HAND_STEPS && victim < 0; s++) begin
              c = int'(tab_hand);
              tab_hand = (tab_hand == NFR - 1) ? '0 : tab_hand + 1'b1;
              if (tab_pins[c] == 0) begin
                if (tab_ref[c]) tab_ref[c] = 1'b0;
                else victim = c;
              end
            end
            old_wb  = tab_valid[victim] && tab_dirty[victim];
            old_blk = old_wb ? tab_block[victim] : '0;
            tab_block[victim] = blk;
            tab_valid[victim] = 1'b1;
            tab_dirty[victim] = 1'b0;
            tab_ref[victim]   = 1'b1;
            tab_pins[victim]  = DEF_PIN_BITS'(1);
            push_result(FRM_PORT_W'(victim), rd ? ST_MISS_LOAD : ST_MISS_ZERO, old_wb,
                        old_blk, 1'b1);
          end
        end
      end
      K_UNPIN: begin
        if (tab_pins[f] == 0) begin
          push_result(f, ST_UNPIN_UNDERFLOW, 1'b0, '0, 1'b1);
        end else begin
          tab_pins[f] = tab_pins[f] - 1'b1;
          push_result(f, ST_DONE, 1'b0, '0, 1'b1);
        end
      end
      K_MARK: begin
        if (tab_valid[f]) tab_dirty[f] = 1'b1;
        push_result(f, ST_DONE, 1'b0, '0, 1'b1);
      end
      default: begin
        for (int i = 0; i < NFR; i++)
          if (tab_valid[i] && tab_dirty[i]) last_dirty = i;
        if (last_dirty < 0) begin
          push_result('0, ST_DONE, 1'b0, '0, 1'b1);
        end else begin
          for (int i = 0; i < NFR; i++) begin
            if (tab_valid[i] && tab_dirty[i]) begin
              push_result(FRM_PORT_W'(i), ST_DONE, 1'b1, tab_block[i], i == last_dirty);
              tab_dirty[i] = 1'b0;
            end
          end
        end
      end
    endcase
  endfunction

  function automatic int free_frames();
    int n;
    n = 0;
    for (int i = 0; i < NFR; i++)
      if (tab_pins[i] == 0) n++;
    return n;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h at %0t",
             results_seen, what, got, want, $time);
    errors++;
  endtask

  // Offer one request and hold it until the block takes it.
  task automatic send_request(kind_t k, logic [BLK_PORT_W-1:0] blk, logic rd,
                              logic [FRM_PORT_W-1:0] f);
    int gap;
    if (tx_idling && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.kind         <= k;
    req.block_number <= blk;
    req.read_wanted  <= rd;
    req.frame_index  <= f;
    do @(posedge clk); while (!req.ready);
    predict_request(k, blk, rd, f);
  endtask

  task automatic wait_results_done();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [BLK_PORT_W-1:0] any_block();
    return BLK_PORT_W'($urandom());
  endfunction

  function automatic logic [FRM_PORT_W-1:0] any_frame();
    return FRM_PORT_W'($urandom_range(0, NFR - 1));
  endfunction

  function automatic logic any_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Result checker
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction, frame", 32'(rsp.frame_out), 32'h0);
      end else begin
        oldest = pending_results.pop_front();
        if (rsp.frame_out !== oldest.frame)
          report_mismatch("frame_out", 32'(rsp.frame_out), 32'(oldest.frame));
        if (rsp.status !== oldest.status)
          report_mismatch("status", 32'(rsp.status), 32'(oldest.status));
        if (rsp.write_back !== oldest.wb)
          report_mismatch("write_back", 32'(rsp.write_back), 32'(oldest.wb));
        if (rsp.write_back_block !== oldest.wb_block)
          report_mismatch("write_back_block", 32'(rsp.write_back_block),
                          32'(oldest.wb_block));
        if (rsp.last !== oldest.last)
          report_mismatch("last", 32'(rsp.last), 32'(oldest.last));
      end
      results_seen++;
    end
  end

  // Result-side ready: random stall bursts, plus a long hold-off on request
  always @(posedge clk) begin
    if (rx_hold_request > 0) begin
      rx_hold_left    = rx_hold_request;
      rx_hold_request = 0;
    end
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      rsp.ready <= 1'b0;
    end else if (!rx_idling) begin
      rsp.ready <= 1'b1;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
      rsp.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      rx_gap_left = $urandom_range(0, 10);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  task automatic test_directed();
    send_request(K_FLUSH, any_block(), 1'b1, any_frame());     // flush with nothing dirty
    send_request(K_UNPIN, any_block(), 1'b0, 6'd0);            // unpin of an empty frame
    send_request(K_MARK, any_block(), 1'b1, 6'd63);            // mark of an empty frame
    send_request(K_FETCH, 24'h000000, 1'b1, 6'd0);
    send_request(K_FETCH, 24'hFFFFFF, 1'b0, 6'd63);
    send_request(K_FETCH, 24'h000000, 1'b0, 6'd0);
    send_request(K_MARK, 24'hFFFFFF, 1'b0, 6'd1);
    send_request(K_FLUSH, 24'h000000, 1'b0, 6'd0);
    send_request(K_MARK, any_block(), 1'b0, 6'd0);
    send_request(K_MARK, any_block(), 1'b1, 6'd1);
    send_request(K_FLUSH, 24'hFFFFFF, 1'b1, 6'd63);
    send_request(K_UNPIN, any_block(), 1'b1, 6'd0);
    send_request(K_UNPIN, any_block(), 1'b0, 6'd0);
    send_request(K_UNPIN, any_block(), 1'b1, 6'd0);
    send_request(K_UNPIN, any_block(), 1'b0, 6'd1);
    send_request(K_MARK, any_block(), 1'b0, 6'd1);
    send_request(K_FETCH, 24'h5A5A5A, 1'b1, 6'd21);
    send_request(K_FETCH, 24'hA5A5A5, 1'b0, 6'd42);
    send_request(K_UNPIN, any_block(), 1'b0, 6'd63);
    send_request(K_FLUSH, any_block(), 1'b0, 6'd0);
    wait_results_done();
  endtask

  // Pin every frame, hit while full, then release a quarter, evict dirty ones and flush.
  task automatic test_all_pinned();
    int serial;
    serial = 0;
    while (free_frames() > 0) begin
      send_request(K_FETCH, BLK_PORT_W'(24'h800000 + serial), any_bit(), any_frame());
      serial++;
    end
    send_request(K_FETCH, 24'hC00000, 1'b1, any_frame());
    send_request(K_FETCH, tab_block[5], 1'b0, any_frame());
    for (int i = 0; i < NFR; i += 4)
      send_request(K_MARK, any_block(), 1'b0, FRM_PORT_W'(i));
    for (int i = 0; i < NFR; i += 4)
      while (tab_pins[i] != 0)
        send_request(K_UNPIN, any_block(), 1'b0, FRM_PORT_W'(i));
    for (int i = 0; i < 8; i++)
      send_request(K_FETCH, BLK_PORT_W'(24'h900000 + i), any_bit(), any_frame());
    send_request(K_FLUSH, any_block(), 1'b0, any_frame());
    wait_results_done();
  endtask

  // Results held off while one block is fetched past the pin limit.
  task automatic test_pin_saturation();
    logic [BLK_PORT_W-1:0] blk;
    int frm;
    blk = 24'h3C3C3C;
    frm = 0;
    rx_hold_request = 300;
    repeat (PIN_MAX + 2)
      send_request(K_FETCH, blk, any_bit(), any_frame());
    for (int i = 0; i < NFR; i++)
      if (tab_valid[i] && tab_block[i] == blk) frm = i;
    repeat (3)
      send_request(K_UNPIN, any_block(), any_bit(), FRM_PORT_W'(frm));
    wait_results_done();
  endtask

  task automatic test_random(int count);
    int pick;
    int start;
    logic [FRM_PORT_W-1:0] f;
    logic [BLK_PORT_W-1:0] blk;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      f    = any_frame();
      if (pick < 40) begin
        // small working set mixes hits and misses
        blk = ($urandom_range(0, 4) == 0) ? any_block() :
              BLK_PORT_W'(24'h100 + $urandom_range(0, 95));
        send_request(K_FETCH, blk, any_bit(), f);
      end else if (pick < 72) begin
        if ($urandom_range(0, 4) != 0) begin
          start = $urandom_range(0, NFR - 1);
          for (int i = 0; i < NFR; i++)
            if (tab_pins[(start + i) % NFR] != 0) f = FRM_PORT_W'((start + i) % NFR);
        end
        send_request(K_UNPIN, any_block(), any_bit(), f);
      end else if (pick < 90) begin
        send_request(K_MARK, any_block(), any_bit(), f);
      end else begin
        send_request(K_FLUSH, any_block(), any_bit(), f);
      end
    end
    wait_results_done();
  endtask

  initial begin
    rst              = 1'b1;
    req.valid        = 1'b0;
    req.kind         = K_FETCH;
    req.block_number = '0;
    req.read_wanted  = 1'b0;
    req.frame_index  = '0;
    errors           = 0;
    results_seen     = 0;
    tx_idling        = 1'b0;
    rx_idling        = 1'b0;
    rx_hold_request  = 0;
    rx_hold_left     = 0;
    rx_gap_left      = 0;
    for (int i = 0; i < NFR; i++) begin
      tab_block[i] = '0;
      tab_valid[i] = 1'b0;
      tab_pins[i]  = '0;
      tab_dirty[i] = 1'b0;
      tab_ref[i]   = 1'b0;
    end
    tab_hand = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    tx_idling = 1'b1;
    rx_idling = 1'b1;
    test_all_pinned();
    test_pin_saturation();
    test_random(40);
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    test_random(25);
    repeat (20) @(posedge clk);

    if (errors == 0 && pending_results.size() == 0) begin
      $display("buffer_pool_clock_replacement_top_tb OK");
    end else begin
      $display("buffer_pool_clock_replacement_top_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("TIMEOUT with %0d results outstanding", pending_results.size());
    $display("buffer_pool_clock_replacement_top_tb NOT OK");
    $finish;
  end

endmodule
